// File: sv/contact_stiffness_accumulator_unit_assert.svh
// Assertion macros used by the checker file of the accumulator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CONTACT_STIFFNESS_ACCUMULATOR_UNIT_ASSERT_SVH
`define CONTACT_STIFFNESS_ACCUMULATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants, types and saturating row adders of the contact stiffness
// accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  localparam int BODY_COUNT = 1024;
  localparam int ADDR_W     = $clog2(BODY_COUNT);
  localparam int BODY_W     = 10;
  localparam int LIMIT_W    = 17;
  localparam logic [LIMIT_W-1:0] BODY_LIMIT = LIMIT_W'(BODY_COUNT);

  localparam int NRM_W   = 16;
  localparam int RAD_W   = 16;
  localparam int KS_W    = 24;
  localparam int TRANS_W = 48;
  localparam int ROT_W   = 64;

  // Shared multiplier: signed A operand, unsigned B operand.
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  // Intermediate widths.
  localparam int SQ_W  = 31;  // n^2 in Q2.30, at most 2^30
  localparam int R2_W  = 32;  // r^2 in Q16.16
  localparam int P_W   = 54;  // ks * n^2
  localparam int FRAC  = 30;
  localparam int R0_W  = P_W + 1 - FRAC;
  localparam int RT_W  = 41;  // (R0 * r^2) >> 16
  localparam int RSH   = 16;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef logic [2:0][TRANS_W-1:0] trans_row_t;
  typedef logic [2:0][ROT_W-1:0]   rot_row_t;
  typedef logic [2:0][KS_W-1:0]    t_row_t;
  typedef logic [2:0][RT_W-1:0]    rt_row_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_RD1,
    ST_WR1,
    ST_RD2,
    ST_WR2,
    ST_RDO,
    ST_OUT
  } state_t;

  // Multiplier schedule of one contact, one product per step up to the drain step.
  typedef enum logic [4:0] {
    STEP_SQ_X,
    STEP_SQ_Y,
    STEP_SQ_Z,
    STEP_R2_A,
    STEP_R2_B,
    STEP_P_X,
    STEP_P_Y,
    STEP_P_Z,
    STEP_D_X,
    STEP_D_Y,
    STEP_D_Z,
    STEP_RT_AX,
    STEP_RT_AY,
    STEP_RT_AZ,
    STEP_RT_BX,
    STEP_RT_BY,
    STEP_RT_BZ,
    STEP_DRAIN
  } step_t;

  typedef struct packed {
    state_t            state;
    step_t             step;
    logic [ADDR_W-1:0] clr_addr;
  } ctrl_t;

  function automatic trans_row_t trans_add_sat(input trans_row_t acc, input t_row_t t);
    trans_row_t           res;
    logic [TRANS_W:0]     sum;
    for (int k = 0; k < 3; k++) begin
      sum    = {1'b0, acc[k]} + (TRANS_W + 1)'(t[k]);
      res[k] = sum[TRANS_W] ? {TRANS_W{1'b1}} : sum[TRANS_W-1:0];
    end
    return res;
  endfunction

  function automatic rot_row_t rot_add_sat(input rot_row_t acc, input rt_row_t rt);
    rot_row_t         res;
    logic [ROT_W:0]   sum;
    for (int k = 0; k < 3; k++) begin
      sum    = {1'b0, acc[k]} + (ROT_W + 1)'(rt[k]);
      res[k] = sum[ROT_W] ? {ROT_W{1'b1}} : sum[ROT_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/contact_stiffness_accumulator_unit.sv
// ----------------------------------------------------------------------------
// contact_stiffness_accumulator_unit
// Per-body diagonal stiffness accumulator: adds contact terms to two bodies
// and returns and clears one body's sums on a read.
// ----------------------------------------------------------------------------
// After reset the block sweeps its body table to zero, one row per cycle, and
// holds busy high until every row is cleared. An item is taken when start is
// high and busy is low. An active accumulate keeps busy high through the
// shared multiplier schedule (17 products and a drain step), then a read
// and a write of each body in turn, since the table registers its read
// data. An inactive contact leaves busy low. A read keeps busy high
// through the states ST_RDO and ST_OUT and shows its result on the out_ ports,
// with out_valid high, for exactly one cycle, from the output register after
// ST_OUT; the receiver cannot stall it, so it must take the beat in that
// cycle. A new item may be started in that same cycle.
`timescale 1ns / 1ps
`default_nettype none

module contact_stiffness_accumulator_unit import csa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic                    in_contact_active,
  input  logic signed [NRM_W-1:0] in_normal_x,
  input  logic signed [NRM_W-1:0] in_normal_y,
  input  logic signed [NRM_W-1:0] in_normal_z,
  input  logic [KS_W-1:0]         in_normal_stiffness,
  input  logic [KS_W-1:0]         in_shear_stiffness,
  input  logic [RAD_W-1:0]        in_first_radius,
  input  logic [RAD_W-1:0]        in_second_radius,
  input  logic [BODY_W-1:0]       in_first_body,
  input  logic [BODY_W-1:0]       in_second_body,
  output logic                    out_valid,
  output logic [BODY_W-1:0]       out_body_index,
  output logic [TRANS_W-1:0]      out_trans_x,
  output logic [TRANS_W-1:0]      out_trans_y,
  output logic [TRANS_W-1:0]      out_trans_z,
  output logic [ROT_W-1:0]        out_rot_x,
  output logic [ROT_W-1:0]        out_rot_y,
  output logic [ROT_W-1:0]        out_rot_z
);

  ctrl_t ctrl;
  logic  accept;

  // Captured item.
  logic [NRM_W-1:0]        mag_r [3];
  logic [RAD_W-1:0]        rad_a_r, rad_b_r;
  logic [KS_W-1:0]         ks_r;
  logic signed [KS_W:0]    diff_r;
  logic [BODY_W-1:0]       body_a_r, body_b_r;

  // Intermediate results.
  logic [SQ_W-1:0] sq_r [3];
  logic [R2_W-1:0] r2_r [2];
  logic [P_W-1:0]  p_r  [3];
  logic [R0_W-1:0] r0_r [3];
  t_row_t          t_r;
  rt_row_t         rt_a_r, rt_b_r;

  // Multiplier.
  logic                      mul_issue;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      prod_valid;
  step_t                     prod_tag;
  logic signed [PROD_W-1:0]  prod;

  // Table.
  logic              rd_en, we;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  trans_row_t        wr_trans, rd_trans;
  rot_row_t          wr_rot, rd_rot;
  logic              range_a, range_b;

  // Result.
  logic                  out_valid_r, out_valid_nxt;
  logic [BODY_W-1:0]     out_body_r;
  trans_row_t            out_trans_r;
  rot_row_t              out_rot_r;

  function automatic logic [NRM_W-1:0] magnitude(input logic [NRM_W-1:0] u);
    return u[NRM_W-1] ? (NRM_W'(0) - u) : u;
  endfunction

  // T = ks + floor((kn - ks) * n^2 / 2^30); the result always fits in KS_W bits.
  function automatic logic [KS_W-1:0] t_term(input logic [KS_W-1:0] ks,
                                             input logic [PROD_W-1:0] p);
    logic signed [PROD_W-FRAC-1:0] s;
    s = $signed((PROD_W - FRAC)'(ks)) + $signed(p[PROD_W-1:FRAC]);
    return s[KS_W-1:0];
  endfunction

  function automatic logic [R0_W-1:0] r0_term(input logic [P_W-1:0] a,
                                               input logic [P_W-1:0] b);
    logic [P_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[P_W:FRAC];
  endfunction

  csa_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .operation      (in_operation),
    .contact_active (in_contact_active),
    .busy           (busy),
    .ctrl           (ctrl)
  );

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r[0] <= magnitude(in_normal_x);
      mag_r[1] <= magnitude(in_normal_y);
      mag_r[2] <= magnitude(in_normal_z);
      rad_a_r  <= in_first_radius;
      rad_b_r  <= in_second_radius;
      ks_r     <= in_shear_stiffness;
      diff_r   <= $signed({1'b0, in_normal_stiffness}) - $signed({1'b0, in_shear_stiffness});
      body_a_r <= in_first_body;
      body_b_r <= in_second_body;
    end
  end

  // Operand selection for the shared multiplier.
  assign mul_issue = (ctrl.state == ST_MUL) && (ctrl.step != STEP_DRAIN);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.step)
      STEP_SQ_X:  begin mul_a = MUL_A_W'(mag_r[0]); mul_b = MUL_B_W'(mag_r[0]); end
      STEP_SQ_Y:  begin mul_a = MUL_A_W'(mag_r[1]); mul_b = MUL_B_W'(mag_r[1]); end
      STEP_SQ_Z:  begin mul_a = MUL_A_W'(mag_r[2]); mul_b = MUL_B_W'(mag_r[2]); end
      STEP_R2_A:  begin mul_a = MUL_A_W'(rad_a_r);  mul_b = MUL_B_W'(rad_a_r);  end
      STEP_R2_B:  begin mul_a = MUL_A_W'(rad_b_r);  mul_b = MUL_B_W'(rad_b_r);  end
      STEP_P_X:   begin mul_a = MUL_A_W'(ks_r);     mul_b = MUL_B_W'(sq_r[0]);  end
      STEP_P_Y:   begin mul_a = MUL_A_W'(ks_r);     mul_b = MUL_B_W'(sq_r[1]);  end
      STEP_P_Z:   begin mul_a = MUL_A_W'(ks_r);     mul_b = MUL_B_W'(sq_r[2]);  end
      STEP_D_X:   begin mul_a = MUL_A_W'(diff_r);   mul_b = MUL_B_W'(sq_r[0]);  end
      STEP_D_Y:   begin mul_a = MUL_A_W'(diff_r);   mul_b = MUL_B_W'(sq_r[1]);  end
      STEP_D_Z:   begin mul_a = MUL_A_W'(diff_r);   mul_b = MUL_B_W'(sq_r[2]);  end
      STEP_RT_AX: begin mul_a = MUL_A_W'(r0_r[0]);  mul_b = MUL_B_W'(r2_r[0]);  end
      STEP_RT_AY: begin mul_a = MUL_A_W'(r0_r[1]);  mul_b = MUL_B_W'(r2_r[0]);  end
      STEP_RT_AZ: begin mul_a = MUL_A_W'(r0_r[2]);  mul_b = MUL_B_W'(r2_r[0]);  end
      STEP_RT_BX: begin mul_a = MUL_A_W'(r0_r[0]);  mul_b = MUL_B_W'(r2_r[1]);  end
      STEP_RT_BY: begin mul_a = MUL_A_W'(r0_r[1]);  mul_b = MUL_B_W'(r2_r[1]);  end
      STEP_RT_BZ: begin mul_a = MUL_A_W'(r0_r[2]);  mul_b = MUL_B_W'(r2_r[1]);  end
      default:    begin mul_a = '0;                 mul_b = '0;                 end
    endcase
  end

  csa_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (mul_issue),
    .tag        (ctrl.step),
    .op_a       (mul_a),
    .op_b       (mul_b),
    .prod_valid (prod_valid),
    .prod_tag   (prod_tag),
    .prod       (prod)
  );

  // Write-back of each product from the multiplier's output register. The rotational base
  // terms are formed once all three ks * n^2 products are in place.
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      case (prod_tag)
        STEP_SQ_X:  sq_r[0] <= prod[SQ_W-1:0];
        STEP_SQ_Y:  sq_r[1] <= prod[SQ_W-1:0];
        STEP_SQ_Z:  sq_r[2] <= prod[SQ_W-1:0];
        STEP_R2_A:  r2_r[0] <= prod[R2_W-1:0];
        STEP_R2_B:  r2_r[1] <= prod[R2_W-1:0];
        STEP_P_X:   p_r[0]  <= prod[P_W-1:0];
        STEP_P_Y:   p_r[1]  <= prod[P_W-1:0];
        STEP_P_Z:   p_r[2]  <= prod[P_W-1:0];
        STEP_D_X: begin
          t_r[0]  <= t_term(ks_r, prod);
          r0_r[0] <= r0_term(p_r[1], p_r[2]);
          r0_r[1] <= r0_term(p_r[2], p_r[0]);
          r0_r[2] <= r0_term(p_r[0], p_r[1]);
        end
        STEP_D_Y:   t_r[1]    <= t_term(ks_r, prod);
        STEP_D_Z:   t_r[2]    <= t_term(ks_r, prod);
        STEP_RT_AX: rt_a_r[0] <= prod[RT_W+RSH-1:RSH];
        STEP_RT_AY: rt_a_r[1] <= prod[RT_W+RSH-1:RSH];
        STEP_RT_AZ: rt_a_r[2] <= prod[RT_W+RSH-1:RSH];
        STEP_RT_BX: rt_b_r[0] <= prod[RT_W+RSH-1:RSH];
        STEP_RT_BY: rt_b_r[1] <= prod[RT_W+RSH-1:RSH];
        STEP_RT_BZ: rt_b_r[2] <= prod[RT_W+RSH-1:RSH];
        default: ;
      endcase
    end
  end

  assign range_a = (LIMIT_W'(body_a_r) < BODY_LIMIT);
  assign range_b = (LIMIT_W'(body_b_r) < BODY_LIMIT);

  // Table access. The second body is read only after the first body's write,
  // so a contact whose two bodies are the same adds both terms in turn.
  always_comb begin
    rd_en    = (ctrl.state == ST_RD1) || (ctrl.state == ST_RD2) || (ctrl.state == ST_RDO);
    rd_addr  = (ctrl.state == ST_RD2) ? ADDR_W'(body_b_r) : ADDR_W'(body_a_r);
    we       = 1'b0;
    wr_addr  = ADDR_W'(body_a_r);
    wr_trans = '0;
    wr_rot   = '0;
    case (ctrl.state)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = ctrl.clr_addr;
      end
      ST_WR1: begin
        we       = range_a;
        wr_trans = trans_add_sat(rd_trans, t_r);
        wr_rot   = rot_add_sat(rd_rot, rt_a_r);
      end
      ST_WR2: begin
        we       = range_b;
        wr_addr  = ADDR_W'(body_b_r);
        wr_trans = trans_add_sat(rd_trans, t_r);
        wr_rot   = rot_add_sat(rd_rot, rt_b_r);
      end
      ST_OUT: begin
        we = range_a;
      end
      default: ;
    endcase
  end

  csa_store u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .we       (we),
    .wr_addr  (wr_addr),
    .wr_trans (wr_trans),
    .wr_rot   (wr_rot),
    .rd_trans (rd_trans),
    .rd_rot   (rd_rot)
  );

  // Result beat.
  assign out_valid_nxt = (ctrl.state == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_body_r  <= body_a_r;
      out_trans_r <= range_a ? rd_trans : '0;
      out_rot_r   <= range_a ? rd_rot : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_body_index = out_body_r;
  assign out_trans_x    = out_trans_r[0];
  assign out_trans_y    = out_trans_r[1];
  assign out_trans_z    = out_trans_r[2];
  assign out_rot_x      = out_rot_r[0];
  assign out_rot_y      = out_rot_r[1];
  assign out_rot_z      = out_rot_r[2];

endmodule

`default_nettype wire

// File: sv/csa_mul.sv
// ----------------------------------------------------------------------------
// csa_mul
// Shared signed-by-unsigned multiplier with a registered product and tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csa_mul import csa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      issue,
  input  step_t                     tag,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0]        op_b,
  output logic                      prod_valid,
  output step_t                     prod_tag,
  output logic signed [PROD_W-1:0]  prod
);

  logic                     valid_r;
  step_t                    tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = op_a * $signed({1'b0, op_b});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tag_r  <= tag;
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = valid_r;
  assign prod_tag   = tag_r;
  assign prod       = prod_r;

endmodule

`default_nettype wire

// File: sv/csa_store.sv
// ----------------------------------------------------------------------------
// csa_store
// Per-body table of translational and rotational sums, one row per body,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csa_store import csa_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  trans_row_t        wr_trans,
  input  rot_row_t          wr_rot,
  output trans_row_t        rd_trans,
  output rot_row_t          rd_rot
);

  trans_row_t trans_mem [BODY_COUNT];
  rot_row_t   rot_mem   [BODY_COUNT];
  trans_row_t rd_trans_r;
  rot_row_t   rd_rot_r;

  always_ff @(posedge clk) begin
    if (we) begin
      trans_mem[wr_addr] <= wr_trans;
      rot_mem[wr_addr]   <= wr_rot;
    end
    if (rd_en) begin
      rd_trans_r <= trans_mem[rd_addr];
      rd_rot_r   <= rot_mem[rd_addr];
    end
  end

  assign rd_trans = rd_trans_r;
  assign rd_rot   = rd_rot_r;

endmodule

`default_nettype wire

// File: sv/csa_seq.sv
// ----------------------------------------------------------------------------
// csa_seq
// Sequencer: table clearing pass, multiplier schedule and table update steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csa_seq import csa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  operation,
  input  logic  contact_active,
  output logic  busy,
  output ctrl_t ctrl
);

  state_t            state_r, state_nxt;
  step_t             step_r, step_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= STEP_SQ_X;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(BODY_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_READ) begin
            state_nxt = ST_RDO;
          end else if (contact_active) begin
            state_nxt = ST_MUL;
            step_nxt  = STEP_SQ_X;
          end
        end
      end
      ST_MUL: begin
        if (step_r == STEP_DRAIN) begin
          state_nxt = ST_RD1;
        end else begin
          step_nxt = step_t'(step_r + 1'b1);
        end
      end
      ST_RD1:  state_nxt = ST_WR1;
      ST_WR1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_WR2;
      ST_WR2:  state_nxt = ST_IDLE;
      ST_RDO:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign ctrl = '{state: state_r, step: step_r, clr_addr: clr_r};

endmodule

`default_nettype wire

// File: sv/csa_checker.sv
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks of the accumulator's command and result behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "contact_stiffness_accumulator_unit_assert.svh"

module csa_checker import csa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_operation,
  input logic [BODY_W-1:0] in_first_body,
  input logic              out_valid,
  input logic [BODY_W-1:0] out_body_index
);

  logic read_take;

  assign read_take = start && !busy && (in_operation == OP_READ);

  // A read keeps the block occupied until its result beat is formed.
  `CSA_ASSERT_NEXT(a_read_goes_busy, read_take, busy, "read not held busy")

  // Result beats last one cycle and never come back to back.
  `CSA_ASSERT_NEXT(a_out_single, out_valid, !out_valid, "result beat longer than one cycle")

  // A result beat only follows a busy cycle.
  `CSA_ASSERT_SAME(a_out_after_busy, out_valid, $past(busy), "result without preceding work")

  // Each result answers a read (via ST_RDO and ST_OUT) and echoes its index.
  `CSA_ASSERT_SAME(a_out_is_read, out_valid, $past(read_take, 3), "result without a read")
  `CSA_ASSERT_SAME(a_out_echo, out_valid, out_body_index == $past(in_first_body, 3), "bad index")

endmodule

bind contact_stiffness_accumulator_unit csa_checker u_csa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .in_first_body  (in_first_body),
  .out_valid      (out_valid),
  .out_body_index (out_body_index)
);

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contact stiffness accumulator. Contacts and
// body reads go in over the start/busy port. A bench-side copy of the body
// table predicts each read beat that has no directed expectation, and the
// result port is checked against the expectation field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import csa_pkg::*;

  localparam int          RANDOM_ITEMS = 1350;
  localparam int          TAIL_CYCLES  = 40;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [63:0] MASK48       = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q30      = 64'h4000_0000;

  typedef struct {
    logic              op;
    logic              active;
    logic [NRM_W-1:0]  nx, ny, nz;
    logic [KS_W-1:0]   kn, ks;
    logic [RAD_W-1:0]  r1, r2;
    logic [BODY_W-1:0] b1, b2;
  } contact_item_t;

  typedef struct {
    logic [BODY_W-1:0] body;
    trans_row_t        trans;
    rot_row_t          rot;
  } body_sums_t;

  typedef struct {
    contact_item_t item;
    bit            typed;
    body_sums_t    want;
  } directed_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_operation;
  logic                    in_contact_active;
  logic signed [NRM_W-1:0] in_normal_x;
  logic signed [NRM_W-1:0] in_normal_y;
  logic signed [NRM_W-1:0] in_normal_z;
  logic [KS_W-1:0]         in_normal_stiffness;
  logic [KS_W-1:0]         in_shear_stiffness;
  logic [RAD_W-1:0]        in_first_radius;
  logic [RAD_W-1:0]        in_second_radius;
  logic [BODY_W-1:0]       in_first_body;
  logic [BODY_W-1:0]       in_second_body;
  logic                    out_valid;
  logic [BODY_W-1:0]       out_body_index;
  logic [TRANS_W-1:0]      out_trans_x;
  logic [TRANS_W-1:0]      out_trans_y;
  logic [TRANS_W-1:0]      out_trans_z;
  logic [ROT_W-1:0]        out_rot_x;
  logic [ROT_W-1:0]        out_rot_y;
  logic [ROT_W-1:0]        out_rot_z;

  trans_row_t      trans_tab [BODY_COUNT];
  rot_row_t        rot_tab [BODY_COUNT];
  body_sums_t      expected_sums[$];
  directed_row_t   directed_rows[$];
  int              mismatches;
  int              cycle_count;

  contact_stiffness_accumulator_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_contact_active   (in_contact_active),
    .in_normal_x         (in_normal_x),
    .in_normal_y         (in_normal_y),
    .in_normal_z         (in_normal_z),
    .in_normal_stiffness (in_normal_stiffness),
    .in_shear_stiffness  (in_shear_stiffness),
    .in_first_radius     (in_first_radius),
    .in_second_radius    (in_second_radius),
    .in_first_body       (in_first_body),
    .in_second_body      (in_second_body),
    .out_valid           (out_valid),
    .out_body_index      (out_body_index),
    .out_trans_x         (out_trans_x),
    .out_trans_y         (out_trans_y),
    .out_trans_z         (out_trans_z),
    .out_rot_x           (out_rot_x),
    .out_rot_y           (out_rot_y),
    .out_rot_z           (out_rot_z)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- predictor

  // Square of a Q1.15 component as Q2.30; the most negative code squares to 1.0.
  function automatic logic [63:0] q115_square(logic [NRM_W-1:0] raw);
    logic [16:0] mag;
    mag = raw[NRM_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    return 64'(mag) * 64'(mag);
  endfunction

  function automatic void credit_body(logic [BODY_W-1:0] body, logic [2:0][63:0] t,
                                      logic [2:0][63:0] r0, logic [RAD_W-1:0] radius);
    logic [63:0] r2;
    logic [63:0] rt;
    logic [64:0] s;
    if (body >= BODY_COUNT) return;
    r2 = 64'(radius) * 64'(radius);
    for (int k = 0; k < 3; k++) begin
      rt = (r0[k] * r2) >> RSH;
      s = 65'(trans_tab[body][k]) + 65'(t[k]);
      trans_tab[body][k] = (s > 65'(MASK48)) ? '1 : s[TRANS_W-1:0];
      s = 65'(rot_tab[body][k]) + 65'(rt);
      rot_tab[body][k] = s[ROT_W] ? '1 : s[ROT_W-1:0];
    end
  endfunction

  function automatic void accumulate_contact(contact_item_t c);
    logic [2:0][63:0] sq;
    logic [2:0][63:0] t;
    logic [2:0][63:0] r0;
    logic [63:0]      others;
    sq[0] = q115_square(c.nx);
    sq[1] = q115_square(c.ny);
    sq[2] = q115_square(c.nz);
    for (int k = 0; k < 3; k++) begin
      others = sq[(k + 1) % 3] + sq[(k + 2) % 3];
      t[k]   = (64'(c.kn) * sq[k] + 64'(c.ks) * (ONE_Q30 - sq[k])) >> FRAC;
      r0[k]  = (64'(c.ks) * others) >> FRAC;
    end
    // A contact on one body twice lands as two separate saturating adds.
    credit_body(c.b1, t, r0, c.r1);
    credit_body(c.b2, t, r0, c.r2);
  endfunction

  function automatic body_sums_t drain_body(logic [BODY_W-1:0] body);
    body_sums_t s;
    s.body  = body;
    s.trans = '0;
    s.rot   = '0;
    if (body < BODY_COUNT) begin
      s.trans         = trans_tab[body];
      s.rot           = rot_tab[body];
      trans_tab[body] = '0;
      rot_tab[body]   = '0;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic contact_item_t accum_item(logic active, logic [NRM_W-1:0] nx,
      logic [NRM_W-1:0] ny, logic [NRM_W-1:0] nz, logic [KS_W-1:0] kn, logic [KS_W-1:0] ks,
      logic [RAD_W-1:0] r1, logic [RAD_W-1:0] r2, logic [BODY_W-1:0] b1,
      logic [BODY_W-1:0] b2);
    contact_item_t c;
    c.op = OP_ACCUM;
    c.active = active;
    c.nx = nx;
    c.ny = ny;
    c.nz = nz;
    c.kn = kn;
    c.ks = ks;
    c.r1 = r1;
    c.r2 = r2;
    c.b1 = b1;
    c.b2 = b2;
    return c;
  endfunction

  function automatic contact_item_t read_item(logic [BODY_W-1:0] body);
    contact_item_t c;
    c    = accum_item(1'b0, '0, '0, '0, '0, '0, '0, '0, body, '0);
    c.op = OP_READ;
    return c;
  endfunction

  function automatic body_sums_t sums(logic [BODY_W-1:0] body, logic [TRANS_W-1:0] tx,
      logic [TRANS_W-1:0] ty, logic [TRANS_W-1:0] tz, logic [ROT_W-1:0] rx,
      logic [ROT_W-1:0] ry, logic [ROT_W-1:0] rz);
    body_sums_t s;
    s.body     = body;
    s.trans[0] = tx;
    s.trans[1] = ty;
    s.trans[2] = tz;
    s.rot[0]   = rx;
    s.rot[1]   = ry;
    s.rot[2]   = rz;
    return s;
  endfunction

  task automatic add_row(contact_item_t item, bit typed, body_sums_t want);
    directed_row_t row;
    row.item  = item;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [NRM_W-1:0] random_component();
    logic [NRM_W-1:0] mag;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: begin
        // Magnitudes up to about 1/sqrt(2) in Q1.15, either sign.
        mag = NRM_W'($urandom_range(0, 23170));
        return $urandom_range(0, 1) ? (16'h0 - mag) : mag;
      end
      default: return NRM_W'($urandom());
    endcase
  endfunction

  function automatic logic [KS_W-1:0] random_stiffness();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return KS_W'($urandom());
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] random_radius();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return RAD_W'($urandom_range(16'h0040, 16'h0400));
      default: return RAD_W'($urandom());
    endcase
  endfunction

  // Most traffic hits a handful of bodies so that sums build up before a read.
  function automatic logic [BODY_W-1:0] random_body();
    if ($urandom_range(0, 3) == 0) return BODY_W'($urandom());
    return BODY_W'($urandom_range(0, 7));
  endfunction

  function automatic contact_item_t random_contact();
    contact_item_t c;
    c = accum_item($urandom_range(0, 9) != 0, random_component(), random_component(),
                   random_component(), random_stiffness(), random_stiffness(),
                   random_radius(), random_radius(), random_body(), random_body());
    if ($urandom_range(0, 9) < 3) c.op = OP_READ;
    return c;
  endfunction

  // Waits out the gap, drives one item and holds it until the block takes it.
  task automatic issue_item(contact_item_t c, int gap, bit typed, body_sums_t want);
    body_sums_t predicted;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start               = 1'b1;
    in_operation        = c.op;
    in_contact_active   = c.active;
    in_normal_x         = c.nx;
    in_normal_y         = c.ny;
    in_normal_z         = c.nz;
    in_normal_stiffness = c.kn;
    in_shear_stiffness  = c.ks;
    in_first_radius     = c.r1;
    in_second_radius    = c.r2;
    in_first_body       = c.b1;
    in_second_body      = c.b2;
    do @(posedge clk); while (busy);
    if (c.op == OP_READ) begin
      predicted = drain_body(c.b1);
      expected_sums.push_back(typed ? want : predicted);
    end else if (c.active) begin
      accumulate_contact(c);
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want,
                             logic [BODY_W-1:0] body);
    if (got !== want)
      flag_mismatch($sformatf("body %0d %s got %h want %h", body, field, got, want));
  endtask

  always @(posedge clk) begin : result_check
    body_sums_t want;
    if (rst_n && out_valid) begin
      if (expected_sums.size() == 0) begin
        flag_mismatch($sformatf("result beat for body %0d with no read pending",
                                out_body_index));
      end else begin
        want = expected_sums.pop_front();
        check_field("body_index", 64'(out_body_index), 64'(want.body), want.body);
        check_field("trans_x", 64'(out_trans_x), 64'(want.trans[0]), want.body);
        check_field("trans_y", 64'(out_trans_y), 64'(want.trans[1]), want.body);
        check_field("trans_z", 64'(out_trans_z), 64'(want.trans[2]), want.body);
        check_field("rot_x", out_rot_x, want.rot[0], want.body);
        check_field("rot_y", out_rot_y, want.rot[1], want.body);
        check_field("rot_z", out_rot_z, want.rot[2], want.body);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    contact_item_t c;
    body_sums_t    blank;
    int            gap;
    int            quiet_run;
    int            counted;

    rst_n               = 1'b0;
    start               = 1'b0;
    in_operation        = OP_ACCUM;
    in_contact_active   = 1'b0;
    in_normal_x         = '0;
    in_normal_y         = '0;
    in_normal_z         = '0;
    in_normal_stiffness = '0;
    in_shear_stiffness  = '0;
    in_first_radius     = '0;
    in_second_radius    = '0;
    in_first_body       = '0;
    in_second_body      = '0;
    mismatches          = 0;
    cycle_count         = 0;
    quiet_run           = 0;
    counted             = 0;
    blank               = sums('0, '0, '0, '0, '0, '0, '0);
    foreach (trans_tab[i]) begin
      trans_tab[i] = '0;
      rot_tab[i]   = '0;
    end

    // Fresh table, and a read whose unused fields are all ones.
    add_row(read_item(10'd0), 1'b1, sums(10'd0, '0, '0, '0, '0, '0, '0));
    c = accum_item(1'b1, '1, '1, '1, '1, '1, '1, '1, 10'd1023, '1);
    c.op = OP_READ;
    add_row(c, 1'b1, sums(10'd1023, '0, '0, '0, '0, '0, '0));
    // An inactive contact leaves the table alone.
    add_row(accum_item(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, '1, '1, '1, '1, 10'd3, 10'd3),
            1'b0, blank);
    add_row(read_item(10'd3), 1'b1, sums(10'd3, '0, '0, '0, '0, '0, '0));
    // Pure normal stiffness along -x: only trans_x picks up kn.
    add_row(accum_item(1'b1, 16'h8000, '0, '0, '1, '0, '1, '1, 10'd5, 10'd6), 1'b0, blank);
    add_row(read_item(10'd5), 1'b1, sums(10'd5, 48'hFF_FFFF, '0, '0, '0, '0, '0));
    add_row(read_item(10'd6), 1'b1, sums(10'd6, 48'hFF_FFFF, '0, '0, '0, '0, '0));
    add_row(read_item(10'd5), 1'b1, sums(10'd5, '0, '0, '0, '0, '0, '0));
    // Zero normal, both ends on one body: shear stiffness lands twice per axis.
    add_row(accum_item(1'b1, '0, '0, '0, '0, '1, 16'h0100, 16'h0100, 10'd7, 10'd7),
            1'b0, blank);
    add_row(read_item(10'd7),
            1'b1, sums(10'd7, 48'h1FF_FFFE, 48'h1FF_FFFE, 48'h1FF_FFFE, '0, '0, '0));
    // Normal along -y, unit radius on one body and zero radius on the other.
    add_row(accum_item(1'b1, '0, 16'h8000, '0, '0, 24'h100, 16'h0100, '0, 10'd9, 10'd10),
            1'b0, blank);
    add_row(read_item(10'd9),
            1'b1, sums(10'd9, 48'h100, '0, 48'h100, 64'h100, '0, 64'h100));
    add_row(read_item(10'd10), 1'b1, sums(10'd10, 48'h100, '0, 48'h100, '0, '0, '0));
    // Non-unit normals and full-scale values, left to the predictor.
    add_row(accum_item(1'b1, 16'h7FFF, 16'h8000, 16'h0001, '1, '1, '1, '1, 10'd1023,
                       10'd0), 1'b0, blank);
    add_row(accum_item(1'b1, 16'hFFFF, 16'h1234, 16'hC000, 24'h123456, 24'hABCDEF,
                       16'h0280, 16'h8000, 10'd0, 10'd0), 1'b0, blank);
    add_row(accum_item(1'b1, 16'h5A82, 16'hA57E, '0, '0, '1, '0, '1, 10'd1023, 10'd12),
            1'b0, blank);
    add_row(read_item(10'd1023), 1'b0, blank);
    add_row(read_item(10'd0), 1'b0, blank);
    add_row(read_item(10'd12), 1'b0, blank);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      issue_item(directed_rows[i].item, $urandom_range(0, 9), directed_rows[i].typed,
                 directed_rows[i].want);

    while (counted < RANDOM_ITEMS) begin
      c = random_contact();
      // Now and then a run of back-to-back items with no idle cycles.
      if (quiet_run > 0) begin
        gap = 0;
        quiet_run--;
      end else begin
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) quiet_run = $urandom_range(10, 40);
      end
      issue_item(c, gap, 1'b0, blank);
      counted++;
    end
    start = 1'b0;

    wait (expected_sums.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
